@@ rtl/core/depq_pkg.sv @@
// ----------------------------------------------------------------------------
// depq_pkg
// Shared command kind codes of the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DEL_MAX = 2'd1;
    localparam logic [1:0] KIND_DEL_MIN = 2'd2;

endpackage

@@ rtl/core/depq_if.sv @@
// ----------------------------------------------------------------------------
// depq_if
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface depq_if #(
    parameter int W = 34
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/depq_mem.sv @@
// ----------------------------------------------------------------------------
// depq_mem
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module depq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/double_ended_priority_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded sorted multiset of signed values with min/max delete.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  channel: payload {kind[1:0], value[31:0]}; kind 0 insert, 1 delete
//        maximum, 2 delete minimum, 3 no-op.
//   rsp  channel: payload {max_value, min_value, is_empty, entry_count,
//        dropped}, one transaction per command.
// Values sit ascending in a RAM at slots 0..count-1. Min and max are kept in
// registers beside it. An insert walks from the top down, moving one entry
// at a time (read, then write one slot up); delete minimum shifts all
// entries down the same way. Delete maximum reads at most the new top slot,
// and a no-op goes straight to the response. Only one command is in flight
// at a time; every entry moved goes through the single RAM port.
// Reset empties the queue (count cleared; RAM contents are left as they are).
// While the result waits unaccepted, no new command is taken.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    depq_if.sink   cmd,
    depq_if.source rsp
);
    import depq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_READMIN, S_WAITMIN, S_OUT
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  pos_reg;
    logic [1:0]     kind_reg;
    logic [31:0]    val_reg;
    logic [31:0]    max_reg, min_reg;
    logic           drop_reg;
    logic           ins_reg;

    logic           we;
    logic [AW-1:0]  addr;
    logic [31:0]    wdata, rdata;

    depq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Insert: pos walks down; S_RD reads pos-1, S_CMP either shifts it to pos
    // or writes the value at pos. Delete min: pos walks up from 1; S_RD reads
    // pos, S_CMP writes it to pos-1.
    logic [CW-1:0] pm1;
    assign pm1 = pos_reg - CW'(1);

    always_comb
    begin
        we    = 1'b0;
        addr  = AW'(pm1);
        wdata = rdata;
        case (state_reg)
            S_RD:
            begin
                addr = ins_reg ? AW'(pm1) : AW'(pos_reg);
            end
            S_CMP:
            begin
                we = 1'b1;
                if (ins_reg)
                begin
                    addr = AW'(pos_reg);
                    if (pos_reg == '0 || !($signed(val_reg) < $signed(rdata)))
                    begin
                        wdata = val_reg;
                    end
                end
                else
                begin
                    addr = AW'(pm1);
                end
            end
            S_READMIN:
            begin
                addr = '0;
            end
            default:
            begin
                addr = AW'(pm1);
            end
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = {(count_reg == '0) ? 32'd0 : max_reg,
                        (count_reg == '0) ? 32'd0 : min_reg,
                        count_reg == '0, 7'(count_reg), drop_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            ins_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        kind_reg <= cmd.data[33:32];
                        val_reg  <= cmd.data[31:0];
                        drop_reg <= 1'b0;
                        state_reg <= S_OUT;
                        case (cmd.data[33:32])
                            KIND_INSERT:
                            begin
                                if (count_reg == CW'(CAPACITY))
                                begin
                                    drop_reg <= 1'b1;
                                end
                                else if (count_reg == '0)
                                begin
                                    // Write slot 0 via the compare path.
                                    ins_reg   <= 1'b1;
                                    pos_reg   <= '0;
                                    max_reg   <= cmd.data[31:0];
                                    min_reg   <= cmd.data[31:0];
                                    state_reg <= S_CMP;
                                end
                                else
                                begin
                                    ins_reg <= 1'b1;
                                    pos_reg <= count_reg;
                                    if ($signed(cmd.data[31:0]) > $signed(max_reg))
                                    begin
                                        max_reg <= cmd.data[31:0];
                                    end
                                    if ($signed(cmd.data[31:0]) < $signed(min_reg))
                                    begin
                                        min_reg <= cmd.data[31:0];
                                    end
                                    state_reg <= S_RD;
                                end
                            end
                            KIND_DEL_MAX:
                            begin
                                if (count_reg > CW'(1))
                                begin
                                    count_reg <= count_reg - CW'(1);
                                    pos_reg   <= count_reg - CW'(1);
                                    state_reg <= S_WAITMIN;
                                end
                                else
                                begin
                                    count_reg <= '0;
                                end
                            end
                            KIND_DEL_MIN:
                            begin
                                if (count_reg > CW'(1))
                                begin
                                    ins_reg   <= 1'b0;
                                    pos_reg   <= CW'(1);
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    count_reg <= '0;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (ins_reg)
                    begin
                        if (pos_reg == '0 || !($signed(val_reg) < $signed(rdata)))
                        begin
                            count_reg <= count_reg + CW'(1);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pos_reg   <= pm1;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (pos_reg == count_reg - CW'(1))
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_READMIN;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_READMIN:
                begin
                    // Delete max: rdata is slot count-1, the new maximum.
                    if (kind_reg == KIND_DEL_MAX)
                    begin
                        max_reg   <= rdata;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_WAITMIN;
                        pos_reg   <= count_reg;
                    end
                end
                S_WAITMIN:
                begin
                    // Delete min: rdata holds the new minimum from slot 0.
                    if (kind_reg == KIND_DEL_MIN)
                    begin
                        min_reg   <= rdata;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_READMIN;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
